// ===== sv/assert_macros.svh =====
// Assertion macros used by the annunciator event core.
// Each macro expands to one labeled concurrent assertion that is disabled
// while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mam_pkg.sv =====
package mam_pkg;

  localparam int DEF_LIGHTS_PER_PANEL = 30;
  localparam int LIGHT_INDEX_W        = 6;
  localparam int CFG_IDX_W            = 3;
  localparam int CFG_DATA_W           = 16;

  typedef enum logic [2:0] {
    OP_SET_LIGHT    = 3'd0,
    OP_FAIL_LIGHT   = 3'd1,
    OP_PRESS        = 3'd2,
    OP_RELEASE      = 3'd3,
    OP_SELECT_POWER = 3'd4,
    OP_ARM_INHIBIT  = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPERATING_MODE    = 3'd0,
    CFG_LAMP_TEST         = 3'd1,
    CFG_UPLINK_TEST       = 3'd2,
    CFG_TONE_ENABLE       = 3'd3,
    CFG_VOLTAGE_THRESHOLD = 3'd4
  } cfg_idx_e;

  localparam logic [1:0]  MODE_BOOST      = 2'd1;
  localparam logic [1:0]  LAMP_TEST_LEFT  = 2'd1;
  localparam logic [1:0]  LAMP_TEST_RIGHT = 2'd2;
  localparam logic [1:0]  SUPPLY_NONE     = 2'd0;
  localparam logic [1:0]  SUPPLY_ONE      = 2'd1;
  localparam logic [1:0]  SUPPLY_TWO      = 2'd2;
  localparam logic        TONE_ENABLE_RST = 1'b1;
  localparam logic [15:0] VTHRESH_RST     = 16'd20000;

  typedef struct packed {
    logic [2:0]               operation;
    logic [LIGHT_INDEX_W-1:0] light_index;
    logic                     flag;
    logic [1:0]               power_source;
    logic [15:0]              bus_voltage;
  } in_word_t;

  typedef struct packed {
    logic alarm_active;
    logic alarm_tone;
    logic left_master_lamp;
    logic right_master_lamp;
    logic light_on;
    logic light_failed;
    logic button_held;
    logic power_ok;
  } out_word_t;

  typedef struct packed {
    logic failed;
    logic lit;
  } light_word_t;

  typedef struct packed {
    logic                     en;
    logic [LIGHT_INDEX_W-1:0] addr;
    light_word_t              word;
  } light_wr_t;

  typedef struct packed {
    logic [1:0]  operating_mode;
    logic [1:0]  lamp_test;
    logic [1:0]  uplink_test;
    logic        tone_enable;
    logic [15:0] voltage_threshold;
  } cfg_t;

endpackage

// ===== sv/mam_light_store.sv =====
module mam_light_store #(
  parameter int LIGHT_COUNT = 2 * mam_pkg::DEF_LIGHTS_PER_PANEL
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [mam_pkg::LIGHT_INDEX_W-1:0]    rd_idx_i,
  input  mam_pkg::light_wr_t                   wr_i,
  output mam_pkg::light_word_t                 rd_word_o
);

  localparam int AW = $clog2(LIGHT_COUNT);

  mam_pkg::light_word_t mem [LIGHT_COUNT];
  logic [LIGHT_COUNT-1:0] valid_q;

  logic                 rd_in_range;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  mam_pkg::light_word_t mem_rd_q;
  logic                 vld_rd_q;
  logic                 byp_q;
  mam_pkg::light_word_t byp_word_q;

  assign rd_in_range = {1'b0, rd_idx_i} < (mam_pkg::LIGHT_INDEX_W + 1)'(LIGHT_COUNT);
  assign rd_addr     = rd_in_range ? rd_idx_i[AW-1:0] : '0;
  assign wr_addr     = wr_i.addr[AW-1:0];

  // Entries never written read as dark and not failed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      vld_rd_q <= valid_q[rd_addr];
      byp_q    <= wr_i.en && (wr_i.addr == rd_idx_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr] <= wr_i.word;
    end
    mem_rd_q   <= mem[rd_addr];
    byp_word_q <= wr_i.word;
  end

  // A write landing on the same edge as the read is forwarded.
  assign rd_word_o = byp_q ? byp_word_q : (vld_rd_q ? mem_rd_q : '0);

endmodule

// ===== sv/mam_event_core.sv =====
`include "assert_macros.svh"

module mam_event_core #(
  parameter int LIGHT_COUNT = 2 * mam_pkg::DEF_LIGHTS_PER_PANEL
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s1_vld_i,
  input  mam_pkg::in_word_t    s1_item_i,
  input  mam_pkg::light_word_t rd_word_i,
  input  mam_pkg::cfg_t        cfg_i,
  output mam_pkg::light_wr_t   wr_o,
  output logic                 res_vld_o,
  output mam_pkg::out_word_t   res_word_o
);

  logic       alarm_q, alarm_d;
  logic       inhibit_q, inhibit_d;
  logic [1:0] supply_q, supply_d;
  logic       button_q, button_d;

  logic                 res_vld_q;
  mam_pkg::out_word_t   res_q, res_d;

  logic                 in_range;
  mam_pkg::light_word_t cur_word;
  mam_pkg::light_word_t new_word;
  logic                 live;
  logic                 pwr;
  logic                 enabled;

  assign in_range = {1'b0, s1_item_i.light_index}
                    < (mam_pkg::LIGHT_INDEX_W + 1)'(LIGHT_COUNT);
  assign cur_word = in_range ? rd_word_i : '0;

  always_comb begin
    alarm_d      = alarm_q;
    inhibit_d    = inhibit_q;
    supply_d     = supply_q;
    button_d     = button_q;
    wr_o.en      = 1'b0;
    wr_o.addr    = s1_item_i.light_index;
    wr_o.word    = cur_word;
    if (s1_vld_i) begin
      unique case (s1_item_i.operation)
        mam_pkg::OP_SET_LIGHT: begin
          if (in_range) begin
            // A rising light raises the alarm unless an armed inhibit eats it.
            if (s1_item_i.flag && !cur_word.lit) begin
              if (inhibit_q) begin
                inhibit_d = 1'b0;
              end else begin
                alarm_d = 1'b1;
              end
            end
            wr_o.en       = 1'b1;
            wr_o.word.lit = s1_item_i.flag;
          end
        end
        mam_pkg::OP_FAIL_LIGHT: begin
          if (in_range) begin
            wr_o.en          = 1'b1;
            wr_o.word.failed = s1_item_i.flag;
          end
        end
        mam_pkg::OP_PRESS: begin
          alarm_d  = 1'b0;
          button_d = 1'b1;
        end
        mam_pkg::OP_RELEASE: begin
          button_d = 1'b0;
        end
        mam_pkg::OP_SELECT_POWER: begin
          supply_d = s1_item_i.power_source;
          if (s1_item_i.power_source != mam_pkg::SUPPLY_NONE) begin
            alarm_d = 1'b1;
          end
        end
        mam_pkg::OP_ARM_INHIBIT: begin
          inhibit_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign new_word = wr_o.en ? wr_o.word : cur_word;
  assign live     = s1_item_i.bus_voltage > cfg_i.voltage_threshold;
  assign pwr      = live && ((supply_d == mam_pkg::SUPPLY_ONE) ||
                             (supply_d == mam_pkg::SUPPLY_TWO));
  assign enabled  = cfg_i.operating_mode != mam_pkg::MODE_BOOST;

  always_comb begin
    res_d.alarm_active      = alarm_d;
    res_d.alarm_tone        = alarm_d && pwr && cfg_i.tone_enable;
    res_d.left_master_lamp  = live && ((alarm_d && enabled) ||
                              ((cfg_i.lamp_test == mam_pkg::LAMP_TEST_LEFT) && enabled) ||
                              cfg_i.uplink_test[0]);
    res_d.right_master_lamp = live && (alarm_d ||
                              (cfg_i.lamp_test == mam_pkg::LAMP_TEST_RIGHT) ||
                              cfg_i.uplink_test[1]);
    res_d.light_on          = new_word.lit;
    res_d.light_failed      = new_word.failed;
    res_d.button_held       = button_d;
    res_d.power_ok          = pwr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q   <= 1'b0;
      inhibit_q <= 1'b0;
      supply_q  <= mam_pkg::SUPPLY_NONE;
      button_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      alarm_q   <= alarm_d;
      inhibit_q <= inhibit_d;
      supply_q  <= supply_d;
      button_q  <= button_d;
      res_vld_q <= s1_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_i) begin
      res_q <= res_d;
    end
  end

  assign res_vld_o  = res_vld_q;
  assign res_word_o = res_q;

  `ASSERT_IMPL(a_wr_in_range, clk_i, rst_ni, wr_o.en, s1_vld_i && in_range, "light write out of range")
  `ASSERT_NEXT(a_press_clears, clk_i, rst_ni, s1_vld_i && (s1_item_i.operation == mam_pkg::OP_PRESS), !alarm_q && res_vld_q && !res_q.alarm_active, "press did not clear alarm")
  `ASSERT_NEXT(a_alarm_rise_cause, clk_i, rst_ni, !alarm_q && !(s1_vld_i && ((s1_item_i.operation == mam_pkg::OP_SET_LIGHT) || (s1_item_i.operation == mam_pkg::OP_SELECT_POWER))), !alarm_q, "alarm raised without cause")
  `ASSERT_NEXT(a_idle_no_result, clk_i, rst_ni, !s1_vld_i, !res_vld_q, "result without item")

endmodule

// ===== sv/master_alarm_annunciator_unit.sv =====
// Master alarm annunciator: caution and warning logic for two panels of lights.
// Input channel: a command word on in_word_i is taken at each rising edge where
// start is high and busy is low. busy never rises, so a word may be issued in
// every cycle. Each word carries one operation: set or fail a light, press or
// release the master alarm button, select a power source, or arm the inhibit.
// Result channel: one result word per command, shown on res_word_o for exactly
// one cycle with out_strobe_o high. The receiver cannot stall; it must sample
// the word in that cycle. Results come out in command order.
// Each command passes the command register and then the result register, whose valid bit is the strobe.
// Throughput: one command per cycle, set by the single registered pass between
// the command register and the result register; the addressed light is read
// from the light memory at the accepting edge and forwarded when the previous
// command writes the same light.
// Configuration: cfg_we_i writes cfg_data_i into the register chosen by cfg_idx_i
// at a rising edge; it is meant to be used only while no command is in flight.
// Reset (rst_ni low, asynchronous): all lights dark and unfailed, alarm, inhibit,
// button and supply cleared, tone enabled, voltage threshold 20000 mV. No
// clearing pass is needed; the command channel is open right after reset.
module master_alarm_annunciator_unit #(
  parameter int LIGHTS_PER_PANEL = mam_pkg::DEF_LIGHTS_PER_PANEL
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  mam_pkg::in_word_t                 in_word_i,
  output logic                              out_strobe_o,
  output mam_pkg::out_word_t                res_word_o,
  input  logic                              cfg_we_i,
  input  logic [mam_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mam_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int LIGHT_COUNT = 2 * LIGHTS_PER_PANEL;

  mam_pkg::cfg_t        cfg_q;
  logic                 accept;
  logic                 s1_vld_q;
  mam_pkg::in_word_t    s1_item_q;
  mam_pkg::light_word_t rd_word;
  mam_pkg::light_wr_t   wr_req;

  // The pass is fully pipelined, so the command channel never pushes back.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers. Writes to indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.operating_mode    <= '0;
      cfg_q.lamp_test         <= '0;
      cfg_q.uplink_test       <= '0;
      cfg_q.tone_enable       <= mam_pkg::TONE_ENABLE_RST;
      cfg_q.voltage_threshold <= mam_pkg::VTHRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mam_pkg::CFG_OPERATING_MODE:    cfg_q.operating_mode    <= cfg_data_i[1:0];
        mam_pkg::CFG_LAMP_TEST:         cfg_q.lamp_test         <= cfg_data_i[1:0];
        mam_pkg::CFG_UPLINK_TEST:       cfg_q.uplink_test       <= cfg_data_i[1:0];
        mam_pkg::CFG_TONE_ENABLE:       cfg_q.tone_enable       <= cfg_data_i[0];
        mam_pkg::CFG_VOLTAGE_THRESHOLD: cfg_q.voltage_threshold <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Command register: the word under evaluation in the single pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_word_i;
    end
  end

  // The light memory is read with the incoming index so that the lit and
  // failed bits are ready alongside the command register.
  mam_light_store #(
    .LIGHT_COUNT (LIGHT_COUNT)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (in_word_i.light_index),
    .wr_i      (wr_req),
    .rd_word_o (rd_word)
  );

  // Latches, light update and lamp logic, ending in the result register.
  mam_event_core #(
    .LIGHT_COUNT (LIGHT_COUNT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_vld_i   (s1_vld_q),
    .s1_item_i  (s1_item_q),
    .rd_word_i  (rd_word),
    .cfg_i      (cfg_q),
    .wr_o       (wr_req),
    .res_vld_o  (out_strobe_o),
    .res_word_o (res_word_o)
  );

endmodule
